### hw/rtl/ccb_pkg.sv
package ccb_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIXEL_BITS = 32;
  localparam int POS_BITS   = COORD_BITS - 1;
  localparam int CALC_W     = COORD_BITS + 3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TEXEL = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_TEX_WIDTH    = 2'd2,
    REG_TEX_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic [POS_BITS-1:0]          src_x;
    logic [POS_BITS-1:0]          src_y;
    logic [COORD_BITS-1:0]        src_w;
    logic [COORD_BITS-1:0]        src_h;
    logic [PIXEL_BITS-1:0]        texel_value;
  } in_item_t;

  typedef struct packed {
    out_kind_t             out_kind;
    logic [POS_BITS-1:0]   out_col;
    logic [POS_BITS-1:0]   out_row;
    logic [PIXEL_BITS-1:0] out_pixel;
    logic                  run_last;
  } out_item_t;

  typedef struct packed {
    logic                  empty;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [POS_BITS-1:0]   dx;
    logic [POS_BITS-1:0]   dy;
    logic [POS_BITS-1:0]   sx;
    logic [POS_BITS-1:0]   sy;
  } clip_res_t;

endpackage

### hw/rtl/ccb_clip.sv
module ccb_clip
  import ccb_pkg::*;
(
  input  in_item_t              cmd,
  input  logic [COORD_BITS-1:0] frame_w,
  input  logic [COORD_BITS-1:0] frame_h,
  input  logic [COORD_BITS-1:0] tex_w,
  input  logic [COORD_BITS-1:0] tex_h,
  output clip_res_t             res
);

  logic signed [CALC_W-1:0] dx0, dy0, sx0, sy0, w0, h0;
  logic signed [CALC_W-1:0] dx1, dy1, sx1, sy1, w1, h1;
  logic signed [CALC_W-1:0] lim_tw, lim_fw, lim_th, lim_fh;
  logic signed [CALC_W-1:0] wa, ha, wf, hf;

  always_comb begin
    dx0 = $signed({{(CALC_W-COORD_BITS){cmd.dest_x[COORD_BITS-1]}}, cmd.dest_x});
    dy0 = $signed({{(CALC_W-COORD_BITS){cmd.dest_y[COORD_BITS-1]}}, cmd.dest_y});
    sx0 = $signed({{(CALC_W-POS_BITS){1'b0}}, cmd.src_x});
    sy0 = $signed({{(CALC_W-POS_BITS){1'b0}}, cmd.src_y});
    w0  = $signed({{(CALC_W-COORD_BITS){1'b0}}, cmd.src_w});
    h0  = $signed({{(CALC_W-COORD_BITS){1'b0}}, cmd.src_h});

    // pull negative corner back to the edge
    if (dx0 < 0) begin
      w1  = w0 + dx0;
      sx1 = sx0 - dx0;
      dx1 = '0;
    end else begin
      w1  = w0;
      sx1 = sx0;
      dx1 = dx0;
    end
    if (dy0 < 0) begin
      h1  = h0 + dy0;
      sy1 = sy0 - dy0;
      dy1 = '0;
    end else begin
      h1  = h0;
      sy1 = sy0;
      dy1 = dy0;
    end

    lim_tw = $signed({{(CALC_W-COORD_BITS){1'b0}}, tex_w}) - sx1;
    lim_th = $signed({{(CALC_W-COORD_BITS){1'b0}}, tex_h}) - sy1;
    lim_fw = $signed({{(CALC_W-COORD_BITS){1'b0}}, frame_w}) - dx1;
    lim_fh = $signed({{(CALC_W-COORD_BITS){1'b0}}, frame_h}) - dy1;

    wa = (lim_tw < w1) ? lim_tw : w1;
    wf = (lim_fw < wa) ? lim_fw : wa;
    ha = (lim_th < h1) ? lim_th : h1;
    hf = (lim_fh < ha) ? lim_fh : ha;

    res.empty = (wf <= 0) || (hf <= 0);
    res.w     = wf[COORD_BITS-1:0];
    res.h     = hf[COORD_BITS-1:0];
    res.dx    = dx1[POS_BITS-1:0];
    res.dy    = dy1[POS_BITS-1:0];
    res.sx    = sx1[POS_BITS-1:0];
    res.sy    = sy1[POS_BITS-1:0];
  end

endmodule

### hw/rtl/clipped_colorkey_blit_unit.sv
// channel | beat                          | handshake
// in      | in_data  (start cmd or texel) | in_valid / in_ready
// out     | out_data (read, write, done)  | out_valid / out_ready
// cfg     | cfg_index, cfg_data           | cfg_valid / cfg_ready (always ready)
//
// One input beat per cycle while in_ready holds. An input register feeds the
// clip and step logic, which pushes zero, one or two beats into a two-entry
// output queue; a nonzero texel answer is a write followed by a read or done,
// and the out port issues one beat a cycle while out_ready is high.
// Sync active-low reset: idle, queue empty, registers 640/480/64/64.
// in_ready drops only when the queue has no room for the held beat's results.
module clipped_colorkey_blit_unit
  import ccb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  logic [COORD_BITS-1:0] frame_w_r, frame_h_r, tex_w_r, tex_h_r;

  logic     in_vld_r;
  in_item_t in_buf_r;

  logic                  busy_r, busy_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [COORD_BITS-1:0] clip_w_r, clip_h_r;
  logic [POS_BITS-1:0]   dst_ox_r, dst_oy_r, src_ox_r, src_oy_r;

  out_item_t   q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  q_cnt_r, q_cnt_nxt;

  clip_res_t clip;
  logic      is_start, pop, proc_go;
  logic [1:0] need;
  logic [2:0] room;
  logic [COORD_BITS:0] col_inc, row_inc;
  logic                wrap, fin, opaque;
  logic [COORD_BITS-1:0] col_step, row_step;
  out_item_t res0, res1, tail;

  ccb_clip u_clip (
    .cmd     (in_buf_r),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .tex_w   (tex_w_r),
    .tex_h   (tex_h_r),
    .res     (clip)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= COORD_BITS'(640);
      frame_h_r <= COORD_BITS'(480);
      tex_w_r   <= COORD_BITS'(64);
      tex_h_r   <= COORD_BITS'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_w_r <= cfg_data;
        REG_FRAME_HEIGHT: frame_h_r <= cfg_data;
        REG_TEX_WIDTH:    tex_w_r   <= cfg_data;
        REG_TEX_HEIGHT:   tex_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // result beats for start commands and texel steps
  always_comb begin
    is_start = (in_buf_r.req_type == REQ_START);
    opaque   = (in_buf_r.texel_value != '0);
    col_inc  = {1'b0, col_r} + 1'b1;
    wrap     = (col_inc >= {1'b0, clip_w_r});
    col_step = wrap ? '0 : col_inc[COORD_BITS-1:0];
    row_inc  = {1'b0, row_r} + (COORD_BITS+1)'(wrap);
    fin      = (row_inc >= {1'b0, clip_h_r});
    row_step = row_inc[COORD_BITS-1:0];

    if (fin) begin
      tail = '{out_kind: KIND_DONE, out_col: '0, out_row: '0, out_pixel: '0, run_last: 1'b1};
    end else begin
      tail = '{out_kind: KIND_READ,
               out_col: src_ox_r + col_step[POS_BITS-1:0],
               out_row: src_oy_r + row_step[POS_BITS-1:0],
               out_pixel: '0, run_last: 1'b1};
    end

    res0 = tail;
    res1 = tail;
    need = 2'd0;
    if (is_start) begin
      need = 2'd1;
      if (clip.empty) begin
        res0 = '{out_kind: KIND_DONE, out_col: '0, out_row: '0, out_pixel: '0, run_last: 1'b1};
      end else begin
        res0 = '{out_kind: KIND_READ, out_col: clip.sx, out_row: clip.sy,
                 out_pixel: '0, run_last: 1'b1};
      end
    end else if (busy_r) begin
      if (opaque) begin
        need = 2'd2;
        res0 = '{out_kind: KIND_WRITE,
                 out_col: dst_ox_r + col_r[POS_BITS-1:0],
                 out_row: dst_oy_r + row_r[POS_BITS-1:0],
                 out_pixel: in_buf_r.texel_value, run_last: 1'b0};
      end else begin
        need = 2'd1;
      end
    end
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = 3'd2 - {1'b0, q_cnt_r} + {2'b0, pop};
  assign proc_go   = in_vld_r && ({1'b0, need} <= room);
  assign in_ready  = !in_vld_r || proc_go;
  assign q_cnt_nxt = proc_go ? (q_cnt_r + need - {1'b0, pop}) : (q_cnt_r - {1'b0, pop});

  always_comb begin
    busy_nxt = busy_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (proc_go) begin
      if (is_start) begin
        busy_nxt = !clip.empty;
        col_nxt  = '0;
        row_nxt  = '0;
      end else if (busy_r) begin
        busy_nxt = !fin;
        col_nxt  = fin ? '0 : col_step;
        row_nxt  = fin ? '0 : row_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      busy_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      busy_r   <= busy_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      q_cnt_r  <= q_cnt_nxt;
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (proc_go) begin
        wr_ptr_r <= wr_ptr_r ^ need[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_buf_r <= in_data;
    end
    if (proc_go && is_start && !clip.empty) begin
      clip_w_r <= clip.w;
      clip_h_r <= clip.h;
      dst_ox_r <= clip.dx;
      dst_oy_r <= clip.dy;
      src_ox_r <= clip.sx;
      src_oy_r <= clip.sy;
    end
    if (proc_go && need != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (proc_go && need == 2'd2) begin
      q_r[!wr_ptr_r] <= res1;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overflow");

  a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (col_r < clip_w_r) && (row_r < clip_h_r))
    else $error("blit position outside clipped area");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && is_start) |=> (busy_r == !$past(clip.empty)))
    else $error("start command left wrong busy state");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == KIND_DONE) |-> out_data.run_last)
    else $error("done beat without run_last");

endmodule

### tb/clipped_colorkey_blit_unit_tb.sv
`timescale 1ns / 1ps

module clipped_colorkey_blit_unit_tb;
  import ccb_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    int        n;
    out_item_t r0;
    out_item_t r1;
  } stim_t;

  typedef struct {
    int w;
    int h;
    int dx;
    int dy;
    int sx;
    int sy;
  } rect_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  clipped_colorkey_blit_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadows
  int fw_r = 640;
  int fh_r = 480;
  int tw_r = 64;
  int th_r = 64;

  // blit state
  bit blit_busy = 1'b0;
  int col_cnt = 0;
  int row_cnt = 0;
  int clip_w = 0;
  int clip_h = 0;
  int dst_x0 = 0;
  int dst_y0 = 0;
  int src_x0 = 0;
  int src_y0 = 0;

  out_item_t expected_beats[$];
  stim_t     cur_stim;
  int        errors = 0;
  int        counted = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  out_item_t pred0;
  out_item_t pred1;
  out_item_t want;
  int        pred_n;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic out_item_t res(out_kind_t k, int col, int row,
                                    logic [PIXEL_BITS-1:0] pix, logic last);
    out_item_t r;
    r.out_kind  = k;
    r.out_col   = col[POS_BITS-1:0];
    r.out_row   = row[POS_BITS-1:0];
    r.out_pixel = pix;
    r.run_last  = last;
    return r;
  endfunction

  function automatic rect_t clip_rect(in_item_t it);
    rect_t r;
    r.dx = {{(32-COORD_BITS){it.dest_x[COORD_BITS-1]}}, it.dest_x};
    r.dy = {{(32-COORD_BITS){it.dest_y[COORD_BITS-1]}}, it.dest_y};
    r.sx = {{(32-POS_BITS){1'b0}}, it.src_x};
    r.sy = {{(32-POS_BITS){1'b0}}, it.src_y};
    r.w  = {{(32-COORD_BITS){1'b0}}, it.src_w};
    r.h  = {{(32-COORD_BITS){1'b0}}, it.src_h};
    if (r.dx < 0) begin
      r.w += r.dx;
      r.sx -= r.dx;
      r.dx = 0;
    end
    if (r.dy < 0) begin
      r.h += r.dy;
      r.sy -= r.dy;
      r.dy = 0;
    end
    if (r.sx + r.w > tw_r) r.w = tw_r - r.sx;
    if (r.sy + r.h > th_r) r.h = th_r - r.sy;
    if (r.dx + r.w > fw_r) r.w = fw_r - r.dx;
    if (r.dy + r.h > fh_r) r.h = fh_r - r.dy;
    return r;
  endfunction

  function automatic int blit_step(input in_item_t it, output out_item_t b0,
                                   output out_item_t b1);
    rect_t                 r;
    out_item_t             beats [2];
    int                    n;
    logic [PIXEL_BITS-1:0] pix;
    beats[0] = '0;
    beats[1] = '0;
    n = 0;
    if (it.req_type == REQ_START) begin
      r = clip_rect(it);
      if (r.w <= 0 || r.h <= 0) begin
        blit_busy = 1'b0;
        beats[0] = res(KIND_DONE, 0, 0, '0, 1'b1);
      end else begin
        blit_busy = 1'b1;
        clip_w = r.w & ((1 << COORD_BITS) - 1);
        clip_h = r.h & ((1 << COORD_BITS) - 1);
        dst_x0 = r.dx & ((1 << POS_BITS) - 1);
        dst_y0 = r.dy & ((1 << POS_BITS) - 1);
        src_x0 = r.sx & ((1 << POS_BITS) - 1);
        src_y0 = r.sy & ((1 << POS_BITS) - 1);
        col_cnt = 0;
        row_cnt = 0;
        beats[0] = res(KIND_READ, src_x0 + col_cnt, src_y0 + row_cnt, '0, 1'b1);
      end
      n = 1;
    end else if (blit_busy) begin
      pix = it.texel_value;
      if (pix != '0) begin
        beats[0] = res(KIND_WRITE, dst_x0 + col_cnt, dst_y0 + row_cnt, pix, 1'b0);
        n = 1;
      end
      col_cnt++;
      if (col_cnt >= clip_w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= clip_h) begin
        blit_busy = 1'b0;
        col_cnt = 0;
        row_cnt = 0;
        beats[n] = res(KIND_DONE, 0, 0, '0, 1'b1);
      end else begin
        beats[n] = res(KIND_READ, src_x0 + col_cnt, src_y0 + row_cnt, '0, 1'b1);
      end
      n++;
    end
    b0 = beats[0];
    b1 = beats[1];
    return n;
  endfunction

  function automatic stim_t cmd(int dx, int dy, int sx, int sy, int w, int h);
    stim_t s;
    s.item = '0;
    s.item.req_type    = REQ_START;
    s.item.dest_x      = dx[COORD_BITS-1:0];
    s.item.dest_y      = dy[COORD_BITS-1:0];
    s.item.src_x       = sx[POS_BITS-1:0];
    s.item.src_y       = sy[POS_BITS-1:0];
    s.item.src_w       = w[COORD_BITS-1:0];
    s.item.src_h       = h[COORD_BITS-1:0];
    s.item.texel_value = $urandom;
    s.fixed = 1'b0;
    s.n     = 0;
    s.r0    = '0;
    s.r1    = '0;
    return s;
  endfunction

  function automatic stim_t tex(logic [PIXEL_BITS-1:0] v);
    stim_t        s;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    s.item = raw[$bits(in_item_t)-1:0];
    s.item.req_type    = REQ_TEXEL;
    s.item.texel_value = v;
    s.fixed = 1'b0;
    s.n     = 0;
    s.r0    = '0;
    s.r1    = '0;
    return s;
  endfunction

  function automatic stim_t pin(stim_t s, int n, out_item_t a, out_item_t b);
    s.fixed = 1'b1;
    s.n     = n;
    s.r0    = a;
    s.r1    = b;
    return s;
  endfunction

  function automatic int pick_coord(int edge_pos);
    case ($urandom_range(0, 4))
      0: return int'($urandom_range(0, 12)) - 6;
      1: return edge_pos - int'($urandom_range(0, 8));
      2: return int'($urandom_range(0, 4095)) - 2048;
      default: return int'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 5);
    if (r < 90) return $urandom_range(0, 16);
    if (r < 97) return $urandom_range(17, 64);
    return $urandom_range(0, 4095);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_texel();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return '1;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fw_r = int'(cfg_data);
          REG_FRAME_HEIGHT: fh_r = int'(cfg_data);
          REG_TEX_WIDTH:    tw_r = int'(cfg_data);
          REG_TEX_HEIGHT:   th_r = int'(cfg_data);
        endcase
      end
      if (in_valid && in_ready) begin
        pred_n = blit_step(in_data, pred0, pred1);
        if (cur_stim.fixed) begin
          pred_n = cur_stim.n;
          pred0  = cur_stim.r0;
          pred1  = cur_stim.r1;
        end
        if (pred_n > 0) begin
          counted++;
          expected_beats.push_back(pred0);
        end
        if (pred_n > 1) expected_beats.push_back(pred1);
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected out beat: kind %0d col %0d row %0d",
                 out_data.out_kind, out_data.out_col, out_data.out_row);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, out_data.out_kind);
            errors++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
            errors++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %h, got %h", want.out_pixel, out_data.out_pixel);
            errors++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_data.run_last);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(stim_t s);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_stim <= s;
    in_data  <= s.item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    int k;
    k = 0;
    while (expected_beats.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [COORD_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic gen_blit();
    stim_t s;
    rect_t r;
    int    area;
    int    nsend;
    s = cmd(pick_coord(fw_r), pick_coord(fh_r), pick_coord(tw_r), pick_coord(th_r),
            pick_size(), pick_size());
    r = clip_rect(s.item);
    area = (r.w > 0 && r.h > 0) ? r.w * r.h : 0;
    nsend = area;
    // long blits are cut short; the next start drops them
    if (area > 40) nsend = $urandom_range(1, 40);
    else if (area > 0 && $urandom_range(0, 9) == 0) nsend = $urandom_range(0, area - 1);
    if ($urandom_range(0, 14) == 0) nsend += $urandom_range(1, 3);
    send_beat(s);
    repeat (nsend) send_beat(tex(pick_texel()));
  endtask

  task automatic run_phase(int fw, int fh, int tw, int th, int target, bit pressure);
    stim_t s;
    bit    held;
    bit    paused;
    held   = 1'b0;
    paused = 1'b0;
    write_reg(REG_FRAME_WIDTH, fw[COORD_BITS-1:0]);
    write_reg(REG_FRAME_HEIGHT, fh[COORD_BITS-1:0]);
    write_reg(REG_TEX_WIDTH, tw[COORD_BITS-1:0]);
    write_reg(REG_TEX_HEIGHT, th[COORD_BITS-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
    counted = 0;
    while (counted < target) begin
      if (pressure && !held && counted >= target / 3) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (pressure && !paused && counted >= (2 * target) / 3) begin
        paused = 1'b1;
        end_burst();
        drain();
      end
      if ($urandom_range(0, 9) == 0) begin
        s = tex($urandom);
        s.item.req_type = 1'($urandom_range(0, 1));
        send_beat(s);
      end else begin
        gen_blit();
      end
    end
    end_burst();
    drain();
  endtask

  initial begin
    stim_t     dir_tab[$];
    out_item_t done1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    cur_stim  = tex('0);
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    done1 = res(KIND_DONE, 0, 0, '0, 1'b1);
    dir_tab.push_back(pin(tex(32'h0000_1234), 0, '0, '0));
    dir_tab.push_back(pin(cmd(0, 0, 0, 0, 1, 1), 1, res(KIND_READ, 0, 0, '0, 1'b1), '0));
    dir_tab.push_back(pin(tex(32'hFFFF_FFFF), 2,
                          res(KIND_WRITE, 0, 0, 32'hFFFF_FFFF, 1'b0), done1));
    dir_tab.push_back(pin(cmd(0, 0, 0, 0, 0, 5), 1, done1, '0));
    dir_tab.push_back(pin(cmd(0, 0, 0, 0, 5, 0), 1, done1, '0));
    dir_tab.push_back(pin(cmd(-2048, 0, 0, 0, 2048, 4), 1, done1, '0));
    dir_tab.push_back(pin(cmd(0, -2048, 0, 0, 4, 2048), 1, done1, '0));
    dir_tab.push_back(pin(cmd(2047, 2047, 0, 0, 2048, 2048), 1, done1, '0));
    dir_tab.push_back(pin(cmd(0, 0, 0, 2047, 1, 1), 1, done1, '0));
    // negative corner: clipped on left and top
    dir_tab.push_back(cmd(-3, -2, 0, 0, 5, 4));
    dir_tab.push_back(tex('0));
    dir_tab.push_back(tex(32'h1));
    dir_tab.push_back(tex('0));
    dir_tab.push_back(tex(32'h8000_0000));
    // bottom-right corner of the frame
    dir_tab.push_back(cmd(638, 479, 62, 0, 8, 3));
    dir_tab.push_back(tex(32'h5));
    dir_tab.push_back(tex('0));
    // restart while busy drops the running blit
    dir_tab.push_back(cmd(0, 0, 10, 10, 3, 3));
    dir_tab.push_back(tex(32'h7));
    dir_tab.push_back(pin(cmd(1, 1, 2047, 0, 1, 1), 1, done1, '0));
    dir_tab.push_back(pin(tex(32'h9), 0, '0, '0));
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    end_burst();
    drain();

    run_phase(2048, 2048, 2048, 2048, 230, 1'b1);
    run_phase(1, 1, 1, 1, 120, 1'b0);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 2048),
              $urandom_range(1, 2048), $urandom_range(1, 2048), 260, 1'b0);
    run_phase(0, 480, 64, 64, 30, 1'b0);
    run_phase(640, 480, 64, 0, 30, 1'b0);
    run_phase(4095, 4095, 4095, 4095, 200, 1'b0);
    run_phase($urandom_range(1, 64), $urandom_range(1, 64),
              $urandom_range(1, 64), $urandom_range(1, 64), 260, 1'b1);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 2048),
              $urandom_range(1, 2048), $urandom_range(1, 2048), 260, 1'b0);
    calm = 1'b1;
    run_phase(640, 480, 64, 64, 240, 1'b0);

    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
      errors++;
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### files.f
hw/rtl/ccb_pkg.sv
hw/rtl/ccb_clip.sv
hw/rtl/clipped_colorkey_blit_unit.sv
tb/clipped_colorkey_blit_unit_tb.sv
